[rtl/core/lbm_pkg.sv]
// Shared types, constants and the dB-to-deflection scale for the IEC level bar meter.
// Used by lbm_ctrl, lbm_dpath and iec_level_bar_meter; depends on nothing else.
`default_nettype none

package lbm_pkg;

    // Field widths.
    localparam int DB_W    = 16;                   // dB values, signed Q8.8
    localparam int DEFL_W  = 17;                   // deflections, unsigned Q9.8
    localparam int LEN_W   = 10;                   // bar positions (LENGTH_BITS)
    localparam int BAR_W   = 10;                   // bar_length register field
    localparam int CFG_W   = 16;                   // configuration write data
    localparam int IDX_W   = 2;                    // configuration register index
    localparam int PROD_W  = DEFL_W + LEN_W;       // span offset times bar length
    localparam int DIV_CNT_W = $clog2(LEN_W);

    // Result beat layout.
    localparam int OUT_BITS    = 4 * LEN_W + DEFL_W + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Deflection of 0 dB on the scale.
    localparam logic [DEFL_W-1:0] FULL_SCALE = DEFL_W'(25600);

    // Reset values of the configuration registers.
    localparam logic signed [DB_W-1:0] LOWER_RST = -16'sd17920;
    localparam logic signed [DB_W-1:0] UPPER_RST = 16'sd1536;
    localparam logic signed [DB_W-1:0] AMBER_RST = -16'sd1536;
    localparam logic [LEN_W-1:0]       LEN_RST   = LEN_W'(100);

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1,
        REG_AMBER = 2'd2,
        REG_LEN   = 2'd3
    } lbm_reg_t;

    // Operand of the scale unit.
    typedef enum logic [1:0] {
        DSEL_LVL = 2'd0,
        DSEL_LOW = 2'd1,
        DSEL_UPP = 2'd2,
        DSEL_AMB = 2'd3
    } lbm_dsel_t;

    // Deflection whose bar position is being worked out.
    typedef enum logic [1:0] {
        PSEL_DV = 2'd0,
        PSEL_DA = 2'd1,
        PSEL_FS = 2'd2,
        PSEL_PK = 2'd3
    } lbm_psel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_in;
        logic      clr_peak;
        logic      defl_en;
        lbm_dsel_t defl_sel;
        logic      span_en;
        logic      pos_sub;
        logic      pos_mul;
        logic      div_step;
        logic      pos_store;
        lbm_psel_t pos_sel;
    } lbm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic range_err;
    } lbm_sts_t;

    // One result item.
    typedef struct packed {
        logic              range_error;
        logic [DEFL_W-1:0] deflection;
        logic              peak_visible;
        logic [LEN_W-1:0]  peak_position;
        logic [LEN_W-1:0]  red_end;
        logic [LEN_W-1:0]  amber_end;
        logic [LEN_W-1:0]  green_end;
    } lbm_res_t;

    // Seven-segment piecewise-linear scale: round-half-up of (d - break) * slope
    // to Q9.8, plus the segment base. Slopes are in quarter percent per dB.
    function automatic logic [DEFL_W-1:0] deflect_of(input logic signed [DB_W-1:0] d);
        logic signed [DB_W+1:0] brk;
        logic signed [DB_W+1:0] above;
        logic [3:0]             slope;
        logic [DEFL_W-1:0]      base;
        logic [DEFL_W+3:0]      prod;
        if (d < -16'sd17920)
        begin
            brk = '0;   slope = 4'd0;  base = '0;
        end
        else if (d < -16'sd15360)
        begin
            brk = -18'sd17920; slope = 4'd1;  base = DEFL_W'(0);
        end
        else if (d < -16'sd12800)
        begin
            brk = -18'sd15360; slope = 4'd2;  base = DEFL_W'(640);
        end
        else if (d < -16'sd10240)
        begin
            brk = -18'sd12800; slope = 4'd3;  base = DEFL_W'(1920);
        end
        else if (d < -16'sd7680)
        begin
            brk = -18'sd10240; slope = 4'd6;  base = DEFL_W'(3840);
        end
        else if (d < -16'sd5120)
        begin
            brk = -18'sd7680;  slope = 4'd8;  base = DEFL_W'(7680);
        end
        else
        begin
            brk = -18'sd5120;  slope = 4'd10; base = DEFL_W'(12800);
        end
        above = {{2{d[DB_W-1]}}, d} - brk;
        prod  = ({4'b0, above[DEFL_W-1:0]} * {{DEFL_W{1'b0}}, slope}) + (DEFL_W+4)'(2);
        return prod[DEFL_W+1:2] + base;
    endfunction

endpackage

`default_nettype wire

[rtl/core/lbm_ctrl.sv]
// Sequencer of the IEC level bar meter: steps the datapath through scale lookups,
// range check and, if in range, four bar positions per level item. Uses lbm_pkg.
`default_nettype none

module lbm_ctrl
    import lbm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_peak_clr,
    output logic          in_ready,
    input  wire logic     out_free,
    output logic          out_load,
    output lbm_cmd_t      cmd,
    input  wire lbm_sts_t sts
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DEFL   = 8'b0000_0010,
        ST_SPAN   = 8'b0000_0100,
        ST_PSUB   = 8'b0000_1000,
        ST_PMUL   = 8'b0001_0000,
        ST_PDIV   = 8'b0010_0000,
        ST_PSTORE = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } lbm_state_t;

    lbm_state_t             state_reg, state_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.defl_sel = lbm_dsel_t'(cnt_reg);
        cmd.pos_sel  = lbm_psel_t'(cnt_reg);
        in_ready     = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_peak_clr)
                    begin
                        cmd.clr_peak = 1'b1;
                    end
                    else
                    begin
                        cmd.load_in = 1'b1;
                        cnt_next    = 2'd0;
                        state_next  = ST_DEFL;
                    end
                end
            end
            ST_DEFL:
            begin
                cmd.defl_en = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                cmd.span_en = 1'b1;
                cnt_next    = 2'd0;
                state_next  = sts.range_err ? ST_FINISH : ST_PSUB;
            end
            ST_PSUB:
            begin
                cmd.pos_sub = 1'b1;
                state_next  = ST_PMUL;
            end
            ST_PMUL:
            begin
                cmd.pos_mul  = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_PDIV;
            end
            ST_PDIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(LEN_W - 1))
                begin
                    state_next = ST_PSTORE;
                end
            end
            ST_PSTORE:
            begin
                cmd.pos_store = 1'b1;
                cnt_next      = cnt_reg + 2'd1;
                state_next    = (cnt_reg == 2'd3) ? ST_FINISH : ST_PSUB;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lbm_dpath.sv]
// Datapath of the IEC level bar meter: level clamp, scale unit, peak hold and a
// shared multiply and bit-serial divide unit for bar positions. Depends on lbm_pkg.
`default_nettype none

module lbm_dpath
    import lbm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lbm_cmd_t               cmd,
    input  wire logic signed [DB_W-1:0] level_db,
    input  wire logic signed [DB_W-1:0] lower_db,
    input  wire logic signed [DB_W-1:0] upper_db,
    input  wire logic signed [DB_W-1:0] amber_db,
    input  wire logic [LEN_W-1:0]       bar_length,
    output lbm_sts_t                    sts,
    output lbm_res_t                    res
);

    logic signed [DB_W-1:0] lvl_reg;
    logic [DEFL_W-1:0]      dv_reg, dl_reg, du_reg, da_reg;
    logic [DEFL_W-1:0]      span_reg;
    logic [DEFL_W-1:0]      peak_reg;
    logic [DEFL_W-1:0]      x_reg;
    logic                   zero_reg, sat_reg;
    logic [DEFL_W-1:0]      rem_reg;
    logic [LEN_W-1:0]       low_reg, q_reg;
    logic [LEN_W-1:0]       pos_reg [4];

    logic signed [DB_W-1:0] lvl_lo, lvl_cl, scale_in;
    logic [DEFL_W-1:0]      scale_out;
    logic [DEFL_W-1:0]      d_sel;
    logic signed [DEFL_W:0] x_diff;
    logic                   x_zero, x_sat;
    logic [PROD_W-1:0]      prod;
    logic [DEFL_W:0]        trial;
    logic                   trial_ge;
    logic [DEFL_W:0]        trial_sub;
    logic                   range_err;
    logic [LEN_W-1:0]       g_raw, a_raw, r_raw, a_fix, r_fix;

    // Clamp: raise to the bottom of the range, then lower to the top.
    always_comb
    begin
        lvl_lo = (level_db < lower_db) ? lower_db : level_db;
        lvl_cl = (lvl_lo > upper_db) ? upper_db : lvl_lo;
    end

    // Scale unit operand.
    always_comb
    begin
        case (cmd.defl_sel)
            DSEL_LVL: scale_in = lvl_reg;
            DSEL_LOW: scale_in = lower_db;
            DSEL_UPP: scale_in = upper_db;
            DSEL_AMB: scale_in = amber_db;
            default:  scale_in = lvl_reg;
        endcase
        scale_out = deflect_of(scale_in);
    end

    assign range_err     = (du_reg <= dl_reg);
    assign sts.range_err = range_err;

    // Offset from the range bottom and its class: at or below bottom, at or past the top.
    always_comb
    begin
        case (cmd.pos_sel)
            PSEL_DV: d_sel = dv_reg;
            PSEL_DA: d_sel = da_reg;
            PSEL_FS: d_sel = FULL_SCALE;
            PSEL_PK: d_sel = peak_reg;
            default: d_sel = dv_reg;
        endcase
        x_diff = $signed({1'b0, d_sel}) - $signed({1'b0, dl_reg});
        x_zero = x_diff[DEFL_W] || (x_diff == '0);
        x_sat  = !x_zero && (x_diff[DEFL_W-1:0] >= span_reg);
    end

    // Multiplier and one restoring divide step.
    always_comb
    begin
        prod      = {{LEN_W{1'b0}}, x_reg} * {{DEFL_W{1'b0}}, bar_length};
        trial     = {rem_reg, low_reg[LEN_W-1]};
        trial_ge  = (trial >= {1'b0, span_reg});
        trial_sub = trial - {1'b0, span_reg};
    end

    // Peak hold.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else if (cmd.clr_peak)
        begin
            peak_reg <= '0;
        end
        else if (cmd.span_en && (dv_reg > peak_reg))
        begin
            peak_reg <= (dv_reg > du_reg) ? du_reg : dv_reg;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            lvl_reg <= lvl_cl;
        end
        if (cmd.defl_en)
        begin
            case (cmd.defl_sel)
                DSEL_LVL: dv_reg <= scale_out;
                DSEL_LOW: dl_reg <= scale_out;
                DSEL_UPP: du_reg <= scale_out;
                DSEL_AMB: da_reg <= scale_out;
                default:  dv_reg <= scale_out;
            endcase
        end
        if (cmd.span_en)
        begin
            span_reg <= du_reg - dl_reg;
        end
        if (cmd.pos_sub)
        begin
            x_reg    <= x_diff[DEFL_W-1:0];
            zero_reg <= x_zero;
            sat_reg  <= x_sat;
        end
        if (cmd.pos_mul)
        begin
            rem_reg <= prod[PROD_W-1:LEN_W];
            low_reg <= prod[LEN_W-1:0];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[DEFL_W-1:0] : trial[DEFL_W-1:0];
            low_reg <= {low_reg[LEN_W-2:0], 1'b0};
            q_reg   <= {q_reg[LEN_W-2:0], trial_ge};
        end
        if (cmd.pos_store)
        begin
            pos_reg[2'(cmd.pos_sel)] <= zero_reg ? '0 : (sat_reg ? bar_length : q_reg);
        end
    end

    // Zone ends from the positions, kept in order; all zero on a range error.
    always_comb
    begin
        if (dv_reg < da_reg)
        begin
            g_raw = pos_reg[PSEL_DV];
            a_raw = pos_reg[PSEL_DV];
            r_raw = pos_reg[PSEL_DV];
        end
        else if (dv_reg <= FULL_SCALE)
        begin
            g_raw = pos_reg[PSEL_DA];
            a_raw = pos_reg[PSEL_DV];
            r_raw = pos_reg[PSEL_DV];
        end
        else
        begin
            g_raw = pos_reg[PSEL_DA];
            a_raw = pos_reg[PSEL_FS];
            r_raw = pos_reg[PSEL_DV];
        end
        a_fix = (a_raw < g_raw) ? g_raw : a_raw;
        r_fix = (r_raw < a_fix) ? a_fix : r_raw;

        res.deflection  = dv_reg;
        res.range_error = range_err;
        if (range_err)
        begin
            res.green_end     = '0;
            res.amber_end     = '0;
            res.red_end       = '0;
            res.peak_position = '0;
            res.peak_visible  = 1'b0;
        end
        else
        begin
            res.green_end     = g_raw;
            res.amber_end     = a_fix;
            res.red_end       = r_fix;
            res.peak_position = pos_reg[PSEL_PK];
            res.peak_visible  = (peak_reg > dl_reg);
        end
    end

endmodule

`default_nettype wire

[rtl/core/iec_level_bar_meter.sv]
// Top level of the IEC level bar meter: configuration registers, result register
// and the controller and datapath. Depends on lbm_pkg, lbm_ctrl and lbm_dpath.
//
//   Port group   Dir   Beat contents
//   s_axis       in    tuser: action; tdata: level_db
//   m_axis       out   tdata: green_end, amber_end, red_end, peak_position,
//                      peak_visible, deflection, range_error
//   cfg          in    cfg_index selects lower_db, upper_db, amber_db, bar_length
//
// A level beat runs four scale lookups, a range check, four bar positions (each a
// subtract, a multiply, LEN_W divider steps and a store) and one handover before the
// next beat is taken; with a range error the bar positions are skipped.
// A peak reset beat is taken while idle, leaves the block ready and gives no result.
// Reset is asynchronous and active low; no clearing pass is needed.
// The handover stalls only while the output register holds a beat not yet taken.
`default_nettype none

module iec_level_bar_meter
    import lbm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [DB_W-1:0]        s_axis_tdata,   // [15:0] level_db
    input  wire logic [0:0]             s_axis_tuser,   // [0] action
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [9:0] green_end, [19:10] amber_end, [29:20] red_end, [39:30] peak_position,
    // [40] peak_visible, [57:41] deflection, [58] range_error, rest zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    logic signed [DB_W-1:0]  lower_reg, upper_reg, amber_reg;
    logic [LEN_W-1:0]        len_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg;
    logic                    out_free, out_load;
    lbm_cmd_t                cmd;
    lbm_sts_t                sts;
    lbm_res_t                res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_RST;
            upper_reg <= UPPER_RST;
            amber_reg <= AMBER_RST;
            len_reg   <= LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (lbm_reg_t'(cfg_index))
                REG_LOWER: lower_reg <= $signed(cfg_data[DB_W-1:0]);
                REG_UPPER: upper_reg <= $signed(cfg_data[DB_W-1:0]);
                REG_AMBER: amber_reg <= $signed(cfg_data[DB_W-1:0]);
                REG_LEN:   len_reg   <= LEN_W'(cfg_data[BAR_W-1:0]);
                default:   ;
            endcase
        end
    end

    lbm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_peak_clr (s_axis_tuser[0]),
        .in_ready    (s_axis_tready),
        .out_free    (out_free),
        .out_load    (out_load),
        .cmd         (cmd),
        .sts         (sts)
    );

    lbm_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .level_db   ($signed(s_axis_tdata)),
        .lower_db   (lower_reg),
        .upper_db   (upper_reg),
        .amber_db   (amber_reg),
        .bar_length (len_reg),
        .sts        (sts),
        .res        (res)
    );

    // Output register: free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= OUT_TDATA_W'({res.range_error, res.deflection, res.peak_visible,
                                          res.peak_position, res.red_end, res.amber_end,
                                          res.green_end});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A result is loaded only when the output register can take it.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending beat");

    // The controller never takes a beat while it hands over a result.
    a_load_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !s_axis_tready)
        else $error("input ready while loading a result");

    // A level beat starts the sequence, so the next cycle is not ready.
    a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]) |=> !s_axis_tready)
        else $error("ready right after a level beat");

    // A peak reset beat keeps the block ready.
    a_clr_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> s_axis_tready)
        else $error("peak reset beat left the block busy");

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for iec_level_bar_meter: directed scale and zone cases, then
// random levels over many register settings with random stalls. Depends on lbm_pkg.

module testbench;
    import lbm_pkg::*;

    // Action codes carried in tuser.
    localparam logic ACT_LEVEL      = 1'b0;
    localparam logic ACT_PEAK_CLEAR = 1'b1;

    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int BEATS_PER_SETTING = 30;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DB_W-1:0]        s_axis_tdata = '0;      // [15:0] level_db
    logic [0:0]             s_axis_tuser = '0;      // [0] action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [9:0] green_end, [19:10] amber_end, [29:20] red_end, [39:30] peak_position,
    // [40] peak_visible, [57:41] deflection, [58] range_error, rest zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // Predictor copy of the registers and the peak hold.
    logic signed [DB_W-1:0] mdl_lower = LOWER_RST;
    logic signed [DB_W-1:0] mdl_upper = UPPER_RST;
    logic signed [DB_W-1:0] mdl_amber = AMBER_RST;
    logic [LEN_W-1:0]       mdl_len   = LEN_RST;
    int                     peak_hold = 0;

    lbm_res_t bar_results_q[$];

    int src_idle_pct = 0;
    int rcv_idle_pct = 0;
    int errors = 0;
    int n_levels = 0;
    int n_clears = 0;
    int n_settings = 0;
    int n_results = 0;
    int idle_cycles = 0;

    iec_level_bar_meter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // One segment of the scale: round-half-up of above * slope / 4, plus the base.
    function automatic int scale_segment(int above, int slope4, int base);
        return ((above * slope4 + 2) >>> 2) + base;
    endfunction

    // IEC 60268-18 deflection in Q9.8 of a Q8.8 dB value.
    function automatic int iec_deflection(int d);
        if (d < -17920) return 0;
        if (d < -15360) return scale_segment(d + 17920, 1, 0);
        if (d < -12800) return scale_segment(d + 15360, 2, 640);
        if (d < -10240) return scale_segment(d + 12800, 3, 1920);
        if (d < -7680)  return scale_segment(d + 10240, 6, 3840);
        if (d < -5120)  return scale_segment(d + 7680, 8, 7680);
        return scale_segment(d + 5120, 10, 12800);
    endfunction

    // Bar position of deflection d, floored, zero at the bottom, saturated at the bar end.
    function automatic logic [LEN_W-1:0] bar_position(int d, int lo, int span,
                                                      logic [LEN_W-1:0] len);
        longint p;
        if (d <= lo) return '0;
        p = (longint'(d - lo) * longint'(len)) / longint'(span);
        if (p > longint'(len)) return len;
        return p[LEN_W-1:0];
    endfunction

    // Expected result of one level beat; also updates the peak hold.
    function automatic lbm_res_t predict_bar(logic signed [DB_W-1:0] level);
        lbm_res_t res;
        int lvl, dv, dl, du, da, span;
        logic [LEN_W-1:0] g, a, r;
        res = '0;
        lvl = level;
        if (lvl < mdl_lower) lvl = mdl_lower;
        if (lvl > mdl_upper) lvl = mdl_upper;
        dv = iec_deflection(lvl);
        dl = iec_deflection(mdl_lower);
        du = iec_deflection(mdl_upper);
        da = iec_deflection(mdl_amber);
        if (dv > peak_hold)
            peak_hold = (dv > du) ? du : dv;
        res.deflection = DEFL_W'(dv);
        if (du <= dl)
        begin
            res.range_error = 1'b1;
        end
        else
        begin
            span = du - dl;
            if (dv < da)
            begin
                g = bar_position(dv, dl, span, mdl_len);
                a = g;
                r = g;
            end
            else if (dv <= int'(FULL_SCALE))
            begin
                g = bar_position(da, dl, span, mdl_len);
                a = bar_position(dv, dl, span, mdl_len);
                r = a;
            end
            else
            begin
                g = bar_position(da, dl, span, mdl_len);
                a = bar_position(int'(FULL_SCALE), dl, span, mdl_len);
                r = bar_position(dv, dl, span, mdl_len);
            end
            if (a < g) a = g;
            if (r < a) r = a;
            res.green_end     = g;
            res.amber_end     = a;
            res.red_end       = r;
            res.peak_position = bar_position(peak_hold, dl, span, mdl_len);
            res.peak_visible  = (peak_hold > dl);
        end
        return res;
    endfunction

    // Send one beat; the prediction is made at the accepting edge.
    task automatic send_beat(input logic act, input logic [DB_W-1:0] level);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= level;
        do @(posedge clk); while (!s_axis_tready);
        if (act == ACT_PEAK_CLEAR)
        begin
            peak_hold = 0;
            n_clears++;
        end
        else
        begin
            bar_results_q.push_back(predict_bar(level));
            n_levels++;
        end
    endtask

    // Drop valid, wait for every expected beat, then let the block settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (bar_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; write enable stays high for a following write.
    task automatic reg_write(input lbm_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_LOWER: mdl_lower = value;
            REG_UPPER: mdl_upper = value;
            REG_AMBER: mdl_amber = value;
            REG_LEN:   mdl_len   = value[LEN_W-1:0];
            default:   ;
        endcase
    endtask

    // Program the whole register set; only called while the block is idle.
    task automatic set_config(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] up,
                              input logic [CFG_W-1:0] amb, input logic [CFG_W-1:0] len);
        reg_write(REG_LOWER, lo);
        reg_write(REG_UPPER, up);
        reg_write(REG_AMBER, amb);
        reg_write(REG_LEN, len);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [DB_W-1:0] clip_db(int v);
        if (v < -32768) return DB_W'(-32768);
        if (v > 32767)  return DB_W'(32767);
        return DB_W'(v);
    endfunction

    // Random level: mostly inside the range, some anywhere, some near a segment break.
    function automatic logic [DB_W-1:0] rand_level();
        int lo, hi, t;
        int breaks[7] = '{-17920, -15360, -12800, -10240, -7680, -5120, 0};
        lo = mdl_lower;
        hi = mdl_upper;
        if (lo > hi)
        begin
            t = lo; lo = hi; hi = t;
        end
        case ($urandom_range(9))
            0, 1, 2, 3: return clip_db(lo - 256 + int'($urandom_range(hi - lo + 512)));
            4, 5:       return DB_W'($urandom());
            6, 7:       return clip_db(breaks[$urandom_range(6)] + int'($urandom_range(8)) - 4);
            8:          return mdl_lower;
            default:    return mdl_upper;
        endcase
    endfunction

    // Random register setting; most have a well-formed range.
    task automatic rand_config();
        int lo, up, amb, t;
        logic [CFG_W-1:0] len;
        case ($urandom_range(5))
            0:
            begin
                lo = -32768; up = 32767;
            end
            1:
            begin
                lo = LOWER_RST; up = UPPER_RST;
            end
            2:
            begin
                lo = $signed(DB_W'($urandom())); up = $signed(DB_W'($urandom()));
            end
            default:
            begin
                lo = int'($urandom_range(24000)) - 21000;
                up = int'($urandom_range(24000)) - 21000;
                if (lo > up)
                begin
                    t = lo; lo = up; up = t;
                end
            end
        endcase
        case ($urandom_range(3))
            0:       amb = $signed(DB_W'($urandom()));
            1:       amb = int'($urandom_range(3000));
            default: amb = (lo <= up) ? lo + int'($urandom_range(up - lo)) : up;
        endcase
        case ($urandom_range(3))
            0:       len = CFG_W'(1023);
            1:       len = CFG_W'(1);
            2:       len = CFG_W'($urandom_range(1023, 1));
            default: len = CFG_W'($urandom());
        endcase
        set_config(DB_W'(lo), DB_W'(up), DB_W'(amb), len);
    endtask

    // Scale extremes and segment breaks at the reset setting, with a peak clear.
    task automatic test_scale_points();
        logic [DB_W-1:0] levels[12] = '{16'h8000, -16'sd17920, -16'sd15360, -16'sd15359,
                                        -16'sd12800, -16'sd10240, -16'sd7680, -16'sd5120,
                                        -16'sd1536, 16'sd0, 16'sd1536, 16'h7FFF};
        foreach (levels[i])
            send_beat(ACT_LEVEL, levels[i]);
        send_beat(ACT_PEAK_CLEAR, 16'hFFFF);
        send_beat(ACT_LEVEL, -16'sd5120);
        wait_idle();
    endtask

    // Upper below lower, and both below the scale bottom.
    task automatic test_range_error();
        set_config(16'sd0, -16'sd5120, -16'sd1536, 16'd100);
        send_beat(ACT_LEVEL, 16'h7FFF);
        send_beat(ACT_LEVEL, 16'h8000);
        wait_idle();
        set_config(-16'sd30000, -16'sd20000, -16'sd25000, 16'd100);
        send_beat(ACT_LEVEL, 16'sd0);
        wait_idle();
    endtask

    // Warning point above 0 dB, longest bar.
    task automatic test_amber_above_zero();
        set_config(-16'sd17920, 16'h7FFF, 16'sd2560, 16'd1023);
        send_beat(ACT_LEVEL, 16'sd1000);
        send_beat(ACT_LEVEL, 16'sd5000);
        send_beat(ACT_LEVEL, 16'h7FFF);
        wait_idle();
    endtask

    // Bar length of zero, upper data bits set.
    task automatic test_zero_length();
        set_config(LOWER_RST, UPPER_RST, AMBER_RST, 16'hFC00);
        send_beat(ACT_LEVEL, 16'sd0);
        send_beat(ACT_LEVEL, 16'h8000);
        wait_idle();
    endtask

    // Random traffic over several settings at one idling mix.
    task automatic test_random_traffic(input int src_pct, input int rcv_pct, input int cfgs);
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        repeat (cfgs)
        begin
            rand_config();
            repeat (BEATS_PER_SETTING)
            begin
                if ($urandom_range(99) < 8)
                    send_beat(ACT_PEAK_CLEAR, DB_W'($urandom()));
                else
                    send_beat(ACT_LEVEL, rand_level());
            end
            wait_idle();
        end
    endtask

    // Main sequence.
    initial
    begin
        src_idle_pct = 8;
        rcv_idle_pct = 72;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_scale_points();
        test_range_error();
        test_amber_above_zero();
        test_zero_length();
        test_random_traffic(8, 72, 6);
        test_random_traffic(72, 8, 6);
        test_random_traffic(0, 0, 6);
        wait_idle();
        $display("Run covered %0d level beats and %0d peak clears over %0d register settings;",
                 n_levels, n_clears, n_settings);
        $display("%0d result beats were checked, %0d mismatches found.", n_results, errors);
        if (errors == 0)
            $display("iec_level_bar_meter verification clean");
        else
            $display("iec_level_bar_meter verification failed");
        $finish;
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Result side: random stalls and a field-by-field check of each accepted beat.
    always @(posedge clk)
    begin
        lbm_res_t got;
        lbm_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_BITS-1:0];
            n_results++;
            if (bar_results_q.size() == 0)
            begin
                $error("result beat with no expected result pending");
                errors++;
            end
            else
            begin
                want = bar_results_q.pop_front();
                check_field("green_end", want.green_end, got.green_end);
                check_field("amber_end", want.amber_end, got.amber_end);
                check_field("red_end", want.red_end, got.red_end);
                check_field("peak_position", want.peak_position, got.peak_position);
                check_field("peak_visible", want.peak_visible, got.peak_visible);
                check_field("deflection", want.deflection, got.deflection);
                check_field("range_error", want.range_error, got.range_error);
                check_field("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1:OUT_BITS]);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Stalled for %0d cycles with %0d results pending.",
                     idle_cycles, bar_results_q.size());
            $display("iec_level_bar_meter verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[sim.f]
rtl/core/lbm_pkg.sv
rtl/core/lbm_ctrl.sv
rtl/core/lbm_dpath.sv
rtl/core/iec_level_bar_meter.sv
dv/testbench.sv
